// ===== design/wmss_pkg.sv =====
// Shared types and constants for the windowed maximum subsequence sum block.
// Used by the score cell and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package wmss_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SCORE_W  = 32;
   localparam int WIN_W    = 7;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [SCORE_W-1:0]  score_type;

   localparam score_type SCORE_MAX = 32'sh7FFF_FFFF;
   localparam score_type SCORE_MIN = 32'sh8000_0000;

   // Control broadcast to every cell of the chain.
   typedef struct packed {
      logic      shift;
      score_type score;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== design/wmss_cell.sv =====
// One cell of the running-maximum chain: holds the maximum score over the
// most recent k+1 items and hands it to the next cell. Depends on wmss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wmss_cell (
   input  wire                       clock,
   input  wmss_pkg::cell_ctrl_type   ctrl,
   input  wmss_pkg::score_type       prev_max,
   input  wire                       sel,
   output wmss_pkg::score_type       max_out,
   output wmss_pkg::score_type       tap
);

   wmss_pkg::score_type max_ff;
   wmss_pkg::score_type max_in;

   // A new score extends every window by one: this cell now covers the new
   // score plus what the previous cell covered before the shift.
   always_comb begin
      if (ctrl.score > prev_max) begin
         max_in = ctrl.score;
      end else begin
         max_in = prev_max;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         max_ff <= max_in;
      end
   end

   assign max_out = max_ff;
   assign tap     = sel ? max_ff : '0;

endmodule

`default_nettype wire

// ===== design/windowed_max_subsequence_sum.sv =====
// Top level of the windowed maximum subsequence sum block.
// Depends on wmss_pkg and wmss_cell.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted item passes through a select cycle and an add cycle: in the
// cycle it is accepted the window maximum is picked from the cell chain and
// registered; then, in the add cycle, the sample is added, saturated, and the
// chain shifts in the new score. No new item is accepted until the add cycle
// is done, so each item is through before the next. A finished result waits in the
// output register; only when that register is still full at the end of the
// add cycle does the block hold. Each cell k keeps the largest score among the
// last k+1 items of the sequence, so the window maximum is simply the cell
// whose depth equals the smaller of the window length and the number of items
// seen. The window length is taken as 1 when written as zero and as
// WINDOW_MAX when written above it. The item marked last closes the sequence:
// its result carries the flag, and the count, best sum and saturation flag
// start over for the next item. No clearing pass is needed after reset.

module windowed_max_subsequence_sum #(
   parameter int WINDOW_MAX = 64
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire  [wmss_pkg::SAMPLE_W-1:0] req_sample,
   input  wire                           req_last,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic [wmss_pkg::SCORE_W-1:0]  rsp_score,
   output logic [wmss_pkg::SCORE_W-1:0]  rsp_best_sum,
   output logic                          rsp_last_res,
   output logic                          rsp_saturated,
   input  wire                           csr_wr_en,
   input  wire  [wmss_pkg::WIN_W-1:0]    csr_wr_data
);

   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
   localparam int WIDE_W = CNT_W + wmss_pkg::WIN_W;
   localparam int SUM_W  = wmss_pkg::SCORE_W + 1;

   // Configuration register.
   logic [wmss_pkg::WIN_W-1:0] win_ff;

   // Sequence state.
   logic [CNT_W-1:0]    seen_ff, seen_in;
   wmss_pkg::score_type best_ff, best_in;
   logic                sat_ff, sat_in;

   // Work stage.
   logic                   busy_ff;
   wmss_pkg::sample_type   sample_ff;
   logic                   last_ff;
   wmss_pkg::score_type    wmax_ff, wmax_in;

   // Output register.
   logic                rsp_valid_ff;
   wmss_pkg::score_type score_ff, score_in;
   wmss_pkg::score_type rbest_ff;
   logic                rlast_ff;
   logic                rsat_ff;

   logic                accept;
   logic                finish;

   // Window selection.
   logic [WIDE_W-1:0]   win_wide;
   logic [WIDE_W-1:0]   seen_wide;
   logic [WIDE_W-1:0]   take_wide;
   logic [CNT_W-1:0]    take;
   wmss_pkg::score_type tap_or;

   // Add and saturate.
   logic signed [SUM_W-1:0] sum;
   logic                    overflow;

   // Cell chain.
   wmss_pkg::cell_ctrl_type ctrl;
   wmss_pkg::score_type     chain [WINDOW_MAX+1];
   wmss_pkg::score_type     taps  [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]   sel;

   assign accept    = req_valid && req_ready;
   assign finish    = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !busy_ff;

   // The window covers at most as many earlier items as have been seen.
   always_comb begin
      seen_wide = WIDE_W'(seen_ff);
      if (win_ff == '0) begin
         win_wide = WIDE_W'(1);
      end else if (WIDE_W'(win_ff) > WIDE_W'(WINDOW_MAX)) begin
         win_wide = WIDE_W'(WINDOW_MAX);
      end else begin
         win_wide = WIDE_W'(win_ff);
      end
      take_wide = (seen_wide < win_wide) ? seen_wide : win_wide;
      take      = take_wide[CNT_W-1:0];
   end

   // At most one cell is selected; with no earlier item none is and the
   // maximum reads as zero. A negative maximum is replaced by zero.
   always_comb begin
      tap_or = '0;
      for (int k = 0; k < WINDOW_MAX; k++) begin
         tap_or = tap_or | taps[k];
      end
      wmax_in = tap_or[wmss_pkg::SCORE_W-1] ? '0 : tap_or;
   end

   // The added term is never negative, so only the upper limit can be hit in
   // practice; both limits are kept for safety.
   always_comb begin
      sum = SUM_W'(sample_ff) + SUM_W'(wmax_ff);
      overflow = 1'b0;
      if (sum > SUM_W'(wmss_pkg::SCORE_MAX)) begin
         score_in = wmss_pkg::SCORE_MAX;
         overflow = 1'b1;
      end else if (sum < SUM_W'(wmss_pkg::SCORE_MIN)) begin
         score_in = wmss_pkg::SCORE_MIN;
         overflow = 1'b1;
      end else begin
         score_in = sum[wmss_pkg::SCORE_W-1:0];
      end
      best_in = (score_in > best_ff) ? score_in : best_ff;
      sat_in  = sat_ff || overflow;
      if (seen_ff == CNT_W'(WINDOW_MAX)) begin
         seen_in = seen_ff;
      end else begin
         seen_in = seen_ff + CNT_W'(1);
      end
   end

   assign ctrl.shift = finish;
   assign ctrl.score = score_in;
   assign chain[0]   = wmss_pkg::SCORE_MIN;

   for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
      assign sel[k] = (take == CNT_W'(k + 1));
      wmss_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .prev_max (chain[k]),
         .sel      (sel[k]),
         .max_out  (chain[k+1]),
         .tap      (taps[k])
      );
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= wmss_pkg::WIN_W'(1);
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seen_ff      <= '0;
         best_ff      <= wmss_pkg::SCORE_MIN;
         sat_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            win_ff <= csr_wr_data;
         end
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (finish) begin
            busy_ff <= 1'b0;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (finish) begin
            if (last_ff) begin
               seen_ff <= '0;
               best_ff <= wmss_pkg::SCORE_MIN;
               sat_ff  <= 1'b0;
            end else begin
               seen_ff <= seen_in;
               best_ff <= best_in;
               sat_ff  <= sat_in;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_sample;
         last_ff   <= req_last;
         wmax_ff   <= wmax_in;
      end
      if (finish) begin
         score_ff <= score_in;
         rbest_ff <= best_in;
         rlast_ff <= last_ff;
         rsat_ff  <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_score     = score_ff;
   assign rsp_best_sum  = rbest_ff;
   assign rsp_last_res  = rlast_ff;
   assign rsp_saturated = rsat_ff;

`ifndef SYNTHESIS
   // The item count never runs past the depth of the chain.
   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= CNT_W'(WINDOW_MAX))
      else $error("item count exceeds chain depth");

   // Closing a sequence leaves a fresh state for the next item.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      finish && last_ff |=> seen_ff == '0 && best_ff == wmss_pkg::SCORE_MIN && !sat_ff)
      else $error("sequence state not cleared after last item");

   // A score is never below its own sample.
   a_score_floor: assert property (@(posedge clock) disable iff (reset)
      finish |=> $signed(rsp_score) >= $signed(SUM_W'($past(sample_ff))))
      else $error("score below its sample");

   // The best sum never falls below the score reported with it.
   a_best_floor: assert property (@(posedge clock) disable iff (reset)
      finish |=> $signed(rsp_best_sum) >= $signed(rsp_score))
      else $error("best sum below score");
`endif

endmodule

`default_nettype wire
